// ===== rtl/pldrt_pkg.sv =====
// shared types, constants and helpers of the per-level dirty region tracker
package pldrt_pkg;

   localparam int COORD_BITS = 15;
   localparam int FIELD_BITS = 16;
   localparam int AXES       = 3;
   localparam int Q_DEPTH    = 2;

   localparam logic [COORD_BITS-1:0] CMAX = '1;

   typedef enum logic [2:0] {
      MODE_ALLOC       = 3'd0,
      MODE_MARK_DIRTY  = 3'd1,
      MODE_MARK_REGION = 3'd2,
      MODE_TRUNCATE    = 3'd3,
      MODE_QUERY       = 3'd4
   } mode_type;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic signed [FIELD_BITS-1:0] field_type;
   // offset plus extent, one bit wider than the fields
   typedef logic signed [FIELD_BITS:0]   span_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] level;
      field_type  first_x;
      field_type  first_y;
      field_type  first_z;
      field_type  second_x;
      field_type  second_y;
      field_type  second_z;
      logic       dirty_value;
      logic [4:0] keep_count;
   } req_type;

   typedef struct packed {
      logic       status;
      logic       is_dirty;
      coord_type  box_lo_x;
      coord_type  box_lo_y;
      coord_type  box_lo_z;
      coord_type  box_hi_x;
      coord_type  box_hi_y;
      coord_type  box_hi_z;
      coord_type  texel_w;
      coord_type  texel_h;
      coord_type  texel_d;
      logic [4:0] levels_now;
   } rsp_type;

   // classified item handed from the front end to the execution side
   typedef struct packed {
      mode_type                   mode;
      logic [4:0]                 level;
      coord_type [AXES-1:0]       size;
      coord_type [AXES-1:0]       reg_lo;
      span_type [AXES-1:0]        reg_end;
      logic                       dirty_value;
      logic [4:0]                 keep_count;
   } cmd_type;

   // one level of the table
   typedef struct packed {
      coord_type [AXES-1:0] size;
      logic                 flag;
      coord_type [AXES-1:0] box_lo;
      coord_type [AXES-1:0] box_hi;
   } entry_type;

   function automatic coord_type sat_coord(input field_type v);
      coord_type r;
      if (v < 0) begin
         r = '0;
      end else if (span_type'(v) > $signed({2'b00, CMAX})) begin
         r = CMAX;
      end else begin
         r = COORD_BITS'(v);
      end
      return r;
   endfunction

endpackage

// ===== rtl/per_level_dirty_region_tracker_core.sv =====
// top level of the per-level dirty region tracker
// Tracks a table of mip levels, each with a texel size, a dirty flag and a
// 3-D dirty box. Items arrive on the req_ channel (valid/ready) with a mode:
// allocate, mark dirty, mark region, truncate or query. Every accepted item
// gives exactly one transfer on the rsp_ channel describing the addressed
// level after the item, or status 1 when the level is out of range.
// The execution side works on one item at a time, a read-modify-write of
// the level table: read on issue, then update and write back together with
// the result, when the result register is free. Only then does it take the
// next item from the queue.
// A two-entry queue sits behind the front end, so req_ready stays high while
// the execution side works or the result register waits; it drops only when
// the queue is full.
// When the receiver stalls, the result holds in the output register and the
// execution side waits; further requests fill the queue and then stall.
// Reset clears the level count and the written marks, so every level reads
// as zero; the table itself is not cleared.
module per_level_dirty_region_tracker_core #(
   parameter int MAX_LEVELS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pldrt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pldrt_pkg::rsp_type rsp_data
);

   logic               fe_valid, fe_ready;
   pldrt_pkg::cmd_type fe_data;
   logic               q_valid, q_ready;
   pldrt_pkg::cmd_type q_data;

   pldrt_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (fe_valid),
      .cmd_ready (fe_ready),
      .cmd_data  (fe_data)
   );

   pldrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   (fe_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   pldrt_back #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_clean_level_box_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_dirty) |->
         (rsp_data.box_hi_x == '0 && rsp_data.box_hi_y == '0 && rsp_data.box_hi_z == '0))
      else $error("clean level reported with a dirty box");

   a_ignored_item_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |->
         (!rsp_data.is_dirty && rsp_data.texel_w == '0 && rsp_data.texel_h == '0
          && rsp_data.texel_d == '0))
      else $error("out of range result carries level contents");

   a_level_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.levels_now} <= 6'(MAX_LEVELS)))
      else $error("level count beyond table depth");
`endif

endmodule

// ===== rtl/pldrt_front.sv =====
// front end: decodes the mode and works out the item-only parts of each transfer
module pldrt_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  pldrt_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output pldrt_pkg::cmd_type cmd_data
);

   pldrt_pkg::field_type first_v  [pldrt_pkg::AXES];
   pldrt_pkg::field_type second_v [pldrt_pkg::AXES];

   assign first_v[0]  = req_data.first_x;
   assign first_v[1]  = req_data.first_y;
   assign first_v[2]  = req_data.first_z;
   assign second_v[0] = req_data.second_x;
   assign second_v[1] = req_data.second_y;
   assign second_v[2] = req_data.second_z;

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

   always_comb begin
      pldrt_pkg::field_type ext;
      cmd_data = '0;
      // unused codes behave as a query
      if (req_data.mode > 3'(pldrt_pkg::MODE_QUERY)) begin
         cmd_data.mode = pldrt_pkg::MODE_QUERY;
      end else begin
         cmd_data.mode = pldrt_pkg::mode_type'(req_data.mode);
      end
      cmd_data.level       = req_data.level;
      cmd_data.dirty_value = req_data.dirty_value;
      cmd_data.keep_count  = req_data.keep_count;
      for (int i = 0; i < pldrt_pkg::AXES; i++) begin
         cmd_data.size[i] = pldrt_pkg::sat_coord(first_v[i]);
         if (first_v[i] < 0) begin
            cmd_data.reg_lo[i] = '0;
         end else begin
            cmd_data.reg_lo[i] = pldrt_pkg::COORD_BITS'(first_v[i]);
         end
         // depth extent is at least one
         if (i == 2 && second_v[i] < 1) begin
            ext = pldrt_pkg::FIELD_BITS'(1);
         end else begin
            ext = second_v[i];
         end
         cmd_data.reg_end[i] = pldrt_pkg::span_type'(first_v[i])
                               + pldrt_pkg::span_type'(ext);
      end
   end

endmodule

// ===== rtl/pldrt_queue.sv =====
// short command queue between the front end and the execution side
module pldrt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pldrt_pkg::cmd_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pldrt_pkg::cmd_type out_data
);

   localparam int DEPTH = pldrt_pkg::Q_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   pldrt_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/pldrt_back.sv =====
// execution side: level table read, update, write back and result register
module pldrt_back #(
   parameter int MAX_LEVELS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  pldrt_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pldrt_pkg::rsp_type rsp_data
);

   localparam int LW = $clog2(MAX_LEVELS + 1);
   localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   pldrt_pkg::entry_type table_mem [MAX_LEVELS];
   pldrt_pkg::entry_type rd_ff;
   pldrt_pkg::cmd_type   cmd_ff;
   logic [MAX_LEVELS-1:0] mask_ff, mask_in;
   logic [LW-1:0]         total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pldrt_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic            pop, fire, wr_en;
   logic [IW-1:0]   idx;
   logic            in_max, in_total, status;
   pldrt_pkg::entry_type cur, new_entry;
   pldrt_pkg::coord_type [pldrt_pkg::AXES-1:0] nb_hi;
   pldrt_pkg::coord_type [pldrt_pkg::AXES-1:0] whole_cur, whole_new;
   logic nb_empty, cur_empty;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign pop       = cmd_valid && cmd_ready;
   assign fire      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign idx      = cmd_ff.level[IW-1:0];
   assign in_max   = ({1'b0, cmd_ff.level} < 6'(MAX_LEVELS));
   assign in_total = ({1'b0, cmd_ff.level} < 6'(total_ff));
   // a level not written since it was created reads as zero
   assign cur      = (in_max && mask_ff[idx]) ? rd_ff : '0;

   // incoming region clipped to the level, and the whole-level boxes
   always_comb begin
      pldrt_pkg::coord_type lim;
      pldrt_pkg::span_type  hi_s;
      nb_empty  = 1'b0;
      cur_empty = 1'b0;
      for (int i = 0; i < pldrt_pkg::AXES; i++) begin
         lim = cur.size[i];
         if (i == 2 && lim == '0) begin
            lim = pldrt_pkg::COORD_BITS'(1);
         end
         whole_cur[i] = lim;
         if ($signed(cmd_ff.reg_end[i]) < $signed({2'b00, lim})) begin
            hi_s = $signed(cmd_ff.reg_end[i]);
         end else begin
            hi_s = $signed({2'b00, lim});
         end
         if (hi_s <= $signed({2'b00, cmd_ff.reg_lo[i]})) begin
            nb_empty = 1'b1;
         end
         nb_hi[i] = hi_s[pldrt_pkg::COORD_BITS-1:0];
         if (cur.box_lo[i] >= cur.box_hi[i]) begin
            cur_empty = 1'b1;
         end
         whole_new[i] = cmd_ff.size[i];
         if (i == 2 && cmd_ff.size[i] == '0) begin
            whole_new[i] = pldrt_pkg::COORD_BITS'(1);
         end
      end
   end

   always_comb begin
      total_in  = total_ff;
      mask_in   = mask_ff;
      new_entry = cur;
      wr_en     = 1'b0;
      status    = 1'b0;
      unique case (cmd_ff.mode)
         pldrt_pkg::MODE_ALLOC: begin
            if (!in_max) begin
               status = 1'b1;
            end else begin
               if (6'(total_ff) < {1'b0, cmd_ff.level} + 6'd1) begin
                  total_in = LW'({1'b0, cmd_ff.level} + 6'd1);
               end
               new_entry.size   = cmd_ff.size;
               new_entry.box_lo = '0;
               new_entry.box_hi = cur.flag ? whole_new : '0;
               wr_en            = 1'b1;
               mask_in[idx]     = 1'b1;
            end
         end
         pldrt_pkg::MODE_TRUNCATE: begin
            if ({1'b0, cmd_ff.keep_count} < 6'(total_ff)) begin
               total_in = LW'(cmd_ff.keep_count);
               for (int k = 0; k < MAX_LEVELS; k++) begin
                  if (6'(k) >= {1'b0, cmd_ff.keep_count}) begin
                     mask_in[k] = 1'b0;
                  end
               end
            end
         end
         pldrt_pkg::MODE_MARK_DIRTY: begin
            if (!(in_max && in_total)) begin
               status = 1'b1;
            end else begin
               new_entry.flag   = cmd_ff.dirty_value;
               new_entry.box_lo = '0;
               new_entry.box_hi = cmd_ff.dirty_value ? whole_cur : '0;
               wr_en            = 1'b1;
               mask_in[idx]     = 1'b1;
            end
         end
         pldrt_pkg::MODE_MARK_REGION: begin
            if (!(in_max && in_total)) begin
               status = 1'b1;
            end else begin
               if (!nb_empty) begin
                  new_entry.flag = 1'b1;
                  if (cur.flag && !cur_empty) begin
                     for (int i = 0; i < pldrt_pkg::AXES; i++) begin
                        new_entry.box_lo[i] = (cmd_ff.reg_lo[i] < cur.box_lo[i])
                                              ? cmd_ff.reg_lo[i] : cur.box_lo[i];
                        new_entry.box_hi[i] = (nb_hi[i] > cur.box_hi[i])
                                              ? nb_hi[i] : cur.box_hi[i];
                     end
                  end else begin
                     new_entry.box_lo = cmd_ff.reg_lo;
                     new_entry.box_hi = nb_hi;
                  end
               end
               wr_en        = 1'b1;
               mask_in[idx] = 1'b1;
            end
         end
         default: begin
            if (!(in_max && in_total)) begin
               status = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      logic show;
      show = !status && in_max && ({1'b0, cmd_ff.level} < 6'(total_in)) && mask_in[idx];
      rsp_data_in            = '0;
      rsp_data_in.status     = status;
      rsp_data_in.levels_now = 5'(total_in);
      if (show) begin
         rsp_data_in.is_dirty = new_entry.flag;
         rsp_data_in.box_lo_x = new_entry.box_lo[0];
         rsp_data_in.box_lo_y = new_entry.box_lo[1];
         rsp_data_in.box_lo_z = new_entry.box_lo[2];
         rsp_data_in.box_hi_x = new_entry.box_hi[0];
         rsp_data_in.box_hi_y = new_entry.box_hi[1];
         rsp_data_in.box_hi_z = new_entry.box_hi[2];
         rsp_data_in.texel_w  = new_entry.size[0];
         rsp_data_in.texel_h  = new_entry.size[1];
         rsp_data_in.texel_d  = new_entry.size[2];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            mask_ff  <= mask_in;
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= cmd_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // level table: read when a command is taken, written back when an item that changes it completes
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= table_mem[cmd_data.level[IW-1:0]];
      end
      if (fire && wr_en) begin
         table_mem[idx] <= new_entry;
      end
   end

endmodule

// ===== sim/tb_per_level_dirty_region_tracker_core.sv =====
`timescale 1ns / 100ps
// testbench for the per-level dirty region tracker core: directed and random items, scored
module tb_per_level_dirty_region_tracker_core;

   localparam int NUM_LEVELS = 16;
   localparam int COORD_MAX = (1 << pldrt_pkg::COORD_BITS) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_OUT_OF_RANGE = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pldrt_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pldrt_pkg::rsp_type rsp_data;

   // shadow copy of the level table
   int shadow_count;
   bit [NUM_LEVELS-1:0] shadow_written;
   int shadow_size [NUM_LEVELS][3];
   bit shadow_flag [NUM_LEVELS];
   int shadow_lo [NUM_LEVELS][3];
   int shadow_hi [NUM_LEVELS][3];

   pldrt_pkg::rsp_type expected_q[$];
   int error_count;
   int cycle_count;

   bit tx_idle_on;
   bit rx_stall_on;
   int burst_left;
   int recent_level;
   int hold_requests;
   int hold_served;
   int hold_left;
   int rx_phase_left;
   bit rx_phase_ready;

   per_level_dirty_region_tracker_core #(
      .MAX_LEVELS(NUM_LEVELS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   // a level not written since it was created starts from zero
   function automatic void refresh_level(input int lv);
      if (!shadow_written[lv]) begin
         for (int a = 0; a < 3; a++) begin
            shadow_size[lv][a] = 0;
            shadow_lo[lv][a] = 0;
            shadow_hi[lv][a] = 0;
         end
         shadow_flag[lv] = 1'b0;
         shadow_written[lv] = 1'b1;
      end
   endfunction

   function automatic void fill_box(input int lv, input bit whole);
      for (int a = 0; a < 3; a++) begin
         shadow_lo[lv][a] = 0;
         shadow_hi[lv][a] = whole ? shadow_size[lv][a] : 0;
      end
      if (whole && shadow_hi[lv][2] < 1) shadow_hi[lv][2] = 1;
   endfunction

   function automatic pldrt_pkg::rsp_type track_level_item(input pldrt_pkg::req_type r);
      pldrt_pkg::rsp_type o;
      int first [3];
      int second [3];
      int lo [3];
      int hi [3];
      int lv;
      int keep;
      int ext;
      int lim;
      bit oor;
      bit incoming_empty;
      bit stored_empty;
      lv = int'(r.level);
      keep = int'(r.keep_count);
      first[0] = int'(r.first_x);
      first[1] = int'(r.first_y);
      first[2] = int'(r.first_z);
      second[0] = int'(r.second_x);
      second[1] = int'(r.second_y);
      second[2] = int'(r.second_z);
      oor = 1'b0;
      incoming_empty = 1'b0;
      stored_empty = 1'b0;
      case (r.mode)
         pldrt_pkg::MODE_ALLOC: begin
            if (lv >= NUM_LEVELS) begin
               oor = 1'b1;
            end else begin
               if (shadow_count < lv + 1) shadow_count = lv + 1;
               refresh_level(lv);
               for (int a = 0; a < 3; a++) shadow_size[lv][a] = clamp_coord(first[a]);
               fill_box(lv, shadow_flag[lv]);
            end
         end
         pldrt_pkg::MODE_TRUNCATE: begin
            if (keep < shadow_count) begin
               for (int k = keep; k < shadow_count && k < NUM_LEVELS; k++)
                  shadow_written[k] = 1'b0;
               shadow_count = keep;
            end
         end
         default: begin
            if (lv >= shadow_count || lv >= NUM_LEVELS) begin
               oor = 1'b1;
            end else if (r.mode == pldrt_pkg::MODE_MARK_DIRTY) begin
               refresh_level(lv);
               shadow_flag[lv] = r.dirty_value;
               fill_box(lv, r.dirty_value);
            end else if (r.mode == pldrt_pkg::MODE_MARK_REGION) begin
               refresh_level(lv);
               for (int a = 0; a < 3; a++) begin
                  ext = second[a];
                  lim = shadow_size[lv][a];
                  if (a == 2 && ext < 1) ext = 1;
                  if (a == 2 && lim < 1) lim = 1;
                  lo[a] = (first[a] < 0) ? 0 : first[a];
                  hi[a] = (first[a] + ext < lim) ? first[a] + ext : lim;
                  if (lo[a] >= hi[a]) incoming_empty = 1'b1;
                  if (shadow_lo[lv][a] >= shadow_hi[lv][a]) stored_empty = 1'b1;
               end
               if (!incoming_empty) begin
                  for (int a = 0; a < 3; a++) begin
                     if (shadow_flag[lv] && !stored_empty) begin
                        if (lo[a] < shadow_lo[lv][a]) shadow_lo[lv][a] = lo[a];
                        if (hi[a] > shadow_hi[lv][a]) shadow_hi[lv][a] = hi[a];
                     end else begin
                        shadow_lo[lv][a] = lo[a];
                        shadow_hi[lv][a] = hi[a];
                     end
                  end
                  shadow_flag[lv] = 1'b1;
               end
            end
         end
      endcase
      o = '0;
      o.status = oor ? STATUS_OUT_OF_RANGE : STATUS_DONE;
      if (!oor && lv < shadow_count && lv < NUM_LEVELS && shadow_written[lv]) begin
         o.is_dirty = shadow_flag[lv];
         o.box_lo_x = pldrt_pkg::coord_type'(clamp_coord(shadow_lo[lv][0]));
         o.box_lo_y = pldrt_pkg::coord_type'(clamp_coord(shadow_lo[lv][1]));
         o.box_lo_z = pldrt_pkg::coord_type'(clamp_coord(shadow_lo[lv][2]));
         o.box_hi_x = pldrt_pkg::coord_type'(clamp_coord(shadow_hi[lv][0]));
         o.box_hi_y = pldrt_pkg::coord_type'(clamp_coord(shadow_hi[lv][1]));
         o.box_hi_z = pldrt_pkg::coord_type'(clamp_coord(shadow_hi[lv][2]));
         o.texel_w = pldrt_pkg::coord_type'(clamp_coord(shadow_size[lv][0]));
         o.texel_h = pldrt_pkg::coord_type'(clamp_coord(shadow_size[lv][1]));
         o.texel_d = pldrt_pkg::coord_type'(clamp_coord(shadow_size[lv][2]));
      end
      o.levels_now = 5'(shadow_count);
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // scoreboard: results checked first, then the accepted request is predicted
   always @(posedge clock) begin : level_scoreboard
      pldrt_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result expected none actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("is_dirty", 32'(want.is_dirty), 32'(rsp_data.is_dirty));
               check_field("box_lo_x", 32'(want.box_lo_x), 32'(rsp_data.box_lo_x));
               check_field("box_lo_y", 32'(want.box_lo_y), 32'(rsp_data.box_lo_y));
               check_field("box_lo_z", 32'(want.box_lo_z), 32'(rsp_data.box_lo_z));
               check_field("box_hi_x", 32'(want.box_hi_x), 32'(rsp_data.box_hi_x));
               check_field("box_hi_y", 32'(want.box_hi_y), 32'(rsp_data.box_hi_y));
               check_field("box_hi_z", 32'(want.box_hi_z), 32'(rsp_data.box_hi_z));
               check_field("texel_w", 32'(want.texel_w), 32'(rsp_data.texel_w));
               check_field("texel_h", 32'(want.texel_h), 32'(rsp_data.texel_h));
               check_field("texel_d", 32'(want.texel_d), 32'(rsp_data.texel_d));
               check_field("levels_now", 32'(want.levels_now), 32'(rsp_data.levels_now));
            end
         end
         if (req_valid && req_ready) expected_q.push_back(track_level_item(req_data));
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_per_level_dirty_region_tracker_core: done, errors");
         $finish;
      end
   end

   // receiver: long hold-off on request, otherwise ready or a stall pattern
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else if (!rx_stall_on) begin
         rsp_ready = 1'b1;
      end else begin
         if (rx_phase_left == 0) begin
            rx_phase_ready = ~rx_phase_ready;
            rx_phase_left = rx_phase_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
         end else begin
            rx_phase_left--;
         end
         rsp_ready = rx_phase_ready;
      end
   end

   task automatic send_item(input pldrt_pkg::req_type item);
      req_data = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
      if (tx_idle_on) begin
         if (burst_left == 0) begin
            repeat ($urandom_range(1, 9)) @(negedge clock);
            burst_left = $urandom_range(0, 15);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_drained;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   function automatic pldrt_pkg::req_type make_item(input logic [2:0] mode, input int level,
                                                    input int fx, input int fy, input int fz,
                                                    input int sx, input int sy, input int sz,
                                                    input bit dv, input int keep);
      pldrt_pkg::req_type r;
      r.mode = mode;
      r.level = 5'(level);
      r.first_x = pldrt_pkg::field_type'(fx);
      r.first_y = pldrt_pkg::field_type'(fy);
      r.first_z = pldrt_pkg::field_type'(fz);
      r.second_x = pldrt_pkg::field_type'(sx);
      r.second_y = pldrt_pkg::field_type'(sy);
      r.second_z = pldrt_pkg::field_type'(sz);
      r.dirty_value = dv;
      r.keep_count = 5'(keep);
      return r;
   endfunction

   // wide_pct: share of items whose coordinates stay fully random
   function automatic pldrt_pkg::req_type random_item(input int wide_pct);
      pldrt_pkg::req_type r;
      int pick;
      int top;
      r.mode = 3'($urandom);
      r.level = 5'($urandom);
      r.first_x = pldrt_pkg::field_type'($urandom);
      r.first_y = pldrt_pkg::field_type'($urandom);
      r.first_z = pldrt_pkg::field_type'($urandom);
      r.second_x = pldrt_pkg::field_type'($urandom);
      r.second_y = pldrt_pkg::field_type'($urandom);
      r.second_z = pldrt_pkg::field_type'($urandom);
      r.dirty_value = 1'($urandom);
      r.keep_count = 5'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 16) r.mode = pldrt_pkg::MODE_ALLOC;
      else if (pick < 32) r.mode = pldrt_pkg::MODE_MARK_DIRTY;
      else if (pick < 70) r.mode = pldrt_pkg::MODE_MARK_REGION;
      else if (pick < 85) r.mode = pldrt_pkg::MODE_QUERY;
      else if (pick < 93) r.mode = pldrt_pkg::MODE_TRUNCATE;
      else r.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      // mostly levels that exist, often the one just addressed
      top = (shadow_count < NUM_LEVELS) ? shadow_count : NUM_LEVELS - 1;
      if ($urandom_range(0, 9) != 0) begin
         if ($urandom_range(0, 2) == 0) r.level = 5'(recent_level);
         else r.level = 5'($urandom_range(0, top));
      end
      recent_level = int'(r.level);
      if ($urandom_range(0, 99) >= wide_pct) begin
         if (r.mode == pldrt_pkg::MODE_ALLOC) begin
            r.first_x = pldrt_pkg::field_type'(int'($urandom_range(0, 40)) - 2);
            r.first_y = pldrt_pkg::field_type'(int'($urandom_range(0, 40)) - 2);
            r.first_z = pldrt_pkg::field_type'(int'($urandom_range(0, 6)) - 1);
         end else begin
            r.first_x = pldrt_pkg::field_type'(int'($urandom_range(0, 50)) - 8);
            r.first_y = pldrt_pkg::field_type'(int'($urandom_range(0, 50)) - 8);
            r.first_z = pldrt_pkg::field_type'(int'($urandom_range(0, 6)) - 2);
            r.second_x = pldrt_pkg::field_type'(int'($urandom_range(0, 40)) - 4);
            r.second_y = pldrt_pkg::field_type'(int'($urandom_range(0, 40)) - 4);
            r.second_z = pldrt_pkg::field_type'(int'($urandom_range(0, 5)) - 1);
         end
         r.keep_count = 5'($urandom_range(0, NUM_LEVELS + 1));
      end
      return r;
   endfunction

   task automatic test_directed;
      tx_idle_on = 1'b0;
      rx_stall_on = 1'b0;
      // empty table, then levels at and past the table size
      send_item(make_item(pldrt_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_MARK_DIRTY, 0, 0, 0, 0, 0, 0, 0, 1, 0));
      send_item(make_item(pldrt_pkg::MODE_ALLOC, 31, 5, 5, 5, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_ALLOC, NUM_LEVELS, 5, 5, 5, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_ALLOC, 3, 10, 20, 0, 0, 0, 0, 0, 0));
      // level created by growth reads as zero
      send_item(make_item(pldrt_pkg::MODE_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_MARK_REGION, 1, 0, 0, 0, 5, 5, 5, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_ALLOC, 15, -32768, 32767, 1, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_QUERY, 15, 0, 0, 0, 0, 0, 0, 0, 0));
      // clean level: region replaces, then merges, empty region ignored
      send_item(make_item(pldrt_pkg::MODE_MARK_REGION, 3, -5, 2, 0, 8, 100, -3, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_MARK_REGION, 3, 6, 1, 0, 2, 2, 1, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_MARK_REGION, 3, 50, 0, 0, 5, 5, 1, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_MARK_REGION, 15, -32768, -32768, -32768,
                          -32768, -32768, -32768, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_MARK_REGION, 15, 32767, 32767, 32767,
                          32767, 32767, 32767, 0, 0));
      // reallocating a dirty level gives the whole level
      send_item(make_item(pldrt_pkg::MODE_ALLOC, 3, 12, 5, 4, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_MARK_DIRTY, 3, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_MARK_DIRTY, 3, 0, 0, 0, 0, 0, 0, 1, 0));
      send_item(make_item(MODE_SPARE_LO, 3, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_SPARE_LO + 3'd1, 20, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_SPARE_HI, 3, 0, 0, 0, 0, 0, 0, 0, 0));
      // truncate: no change, drop the addressed level, then regrow
      send_item(make_item(pldrt_pkg::MODE_TRUNCATE, 3, 0, 0, 0, 0, 0, 0, 0, 31));
      send_item(make_item(pldrt_pkg::MODE_TRUNCATE, 3, 0, 0, 0, 0, 0, 0, 0, 2));
      send_item(make_item(pldrt_pkg::MODE_QUERY, 3, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_ALLOC, 2, 7, 7, 7, 0, 0, 0, 0, 0));
      send_item(make_item(pldrt_pkg::MODE_TRUNCATE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      wait_drained;
   endtask

   // no idling, frequent hits on the same level
   task automatic test_back_to_back;
      tx_idle_on = 1'b0;
      rx_stall_on = 1'b0;
      repeat (300) send_item(random_item(5));
      wait_drained;
   endtask

   task automatic test_idle_random;
      tx_idle_on = 1'b1;
      rx_stall_on = 1'b1;
      repeat (1400) send_item(random_item(15));
      wait_drained;
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure;
      tx_idle_on = 1'b0;
      rx_stall_on = 1'b0;
      @(posedge clock);
      hold_requests++;
      @(negedge clock);
      repeat (60) send_item(random_item(10));
      wait_drained;
   endtask

   task automatic test_receiver_stall;
      tx_idle_on = 1'b0;
      rx_stall_on = 1'b1;
      repeat (150) send_item(random_item(10));
      wait_drained;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed;
      test_back_to_back;
      test_idle_random;
      test_backpressure;
      test_receiver_stall;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_per_level_dirty_region_tracker_core: done, clean");
      end else begin
         $display("tb_per_level_dirty_region_tracker_core: done, errors");
      end
      $finish;
   end

endmodule
